### src/msc_pkg.sv
// Shared types and constants for the max segment cut counter.
`default_nettype none

package msc_pkg;

    localparam int LEN_W     = 12;
    localparam int COUNT_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_PIECE = 3;

    localparam logic [LEN_W-1:0]   PIECE_RST = LEN_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_C = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

endpackage

`default_nettype wire

### src/msc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

### src/max_segment_cut_count.sv
// Top level: most pieces in an exact cut of a rod, three allowed piece lengths.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------
//  input   | i_valid     | o_ready     | i_rod_length
//  output  | o_valid     | i_ready     | o_piece_count, o_possible
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item is worked in a single pass over the count table, one table entry per
// cycle (an item of length 0 skips the pass); the table is held in two mirrored
// RAMs giving three reads a cycle.
// Reset clears control state and sets all piece lengths to 1; the table needs no clear.
// The next item is taken while a result waits on o_valid; a finished item holds
// in its last state until the output register frees up.
`default_nettype none

module max_segment_cut_count
    import msc_pkg::*;
#(
    parameter int MAX_LENGTH = 4095
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [LEN_W-1:0]     i_rod_length,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [COUNT_W-1:0]   o_piece_count,
    output logic                      o_possible,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_LENGTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW;
    localparam int DW    = ((AW > LEN_W) ? AW : LEN_W) + 1;

    localparam logic [DW-1:0] MAX_LEN_EXT   = DW'(MAX_LENGTH);
    localparam logic [DW-1:0] COUNT_MAX_EXT = DW'(COUNT_MAX);

    typedef struct packed {
        logic          valid;
        logic [CW-1:0] count;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // configuration
    logic [LEN_W-1:0] r_piece [NUM_PIECE];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piece[0] <= PIECE_RST;
            r_piece[1] <= PIECE_RST;
            r_piece[2] <= PIECE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PIECE_A: r_piece[0] <= i_cfg_data;
                CFG_PIECE_B: r_piece[1] <= i_cfg_data;
                CFG_PIECE_C: r_piece[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    t_state r_state, n_state;
    logic   in_xfer, out_free, issue, done, load_out, too_long, len_zero;

    logic          r_issuing;
    logic [AW-1:0] r_iss;
    logic [AW-1:0] r_n;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;

    logic               r_res_possible;
    logic [COUNT_W-1:0] r_res_count;
    logic               r_out_vld;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_vld || i_ready;
    assign too_long = DW'(i_rod_length) > MAX_LEN_EXT;
    assign len_zero = i_rod_length == '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (too_long || len_zero) ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN: begin
                if (done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        issue    = 1'b0;
        done     = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_RUN: begin
                issue = r_issuing;
                done  = r_cmp_vld && (r_cmp_idx == r_n);
            end
            ST_HOLD: load_out = out_free;
            default: ;
        endcase
    end

    // table reads: entry i looks back at i - p for each piece p
    t_entry        rd_data [NUM_PIECE];
    t_entry        cur     [NUM_PIECE];
    logic [AW-1:0] rd_addr [NUM_PIECE];
    logic [2:0]    use_k, fwd_k;
    logic [2:0]    r_use, r_fwd;
    t_entry        r_fwd_data;
    t_entry        calc_entry;
    t_entry        wr_data;
    logic [AW-1:0] wr_addr;
    logic          we;
    logic [DW-1:0] iss_ext;

    assign iss_ext = DW'(r_iss);

    always_comb begin
        for (int k = 0; k < NUM_PIECE; k++) begin
            use_k[k]   = (r_piece[k] != '0) && (DW'(r_piece[k]) <= iss_ext);
            rd_addr[k] = AW'(iss_ext - DW'(r_piece[k]));
            // the entry being written this cycle is not yet in the RAM
            fwd_k[k]   = r_cmp_vld && (rd_addr[k] == r_cmp_idx);
        end
    end

    // best candidate over the three lookbacks
    always_comb begin
        calc_entry = '0;
        for (int k = 0; k < NUM_PIECE; k++) begin
            cur[k] = r_fwd[k] ? r_fwd_data : rd_data[k];
            if (r_use[k] && cur[k].valid) begin
                if (!calc_entry.valid || (cur[k].count + CW'(1)) > calc_entry.count) begin
                    calc_entry.valid = 1'b1;
                    calc_entry.count = cur[k].count + CW'(1);
                end
            end
        end
    end

    always_comb begin
        if (r_cmp_vld) begin
            we      = 1'b1;
            wr_addr = r_cmp_idx;
            wr_data = calc_entry;
        end else begin
            // length 0 is always reachable with no pieces
            we            = in_xfer && !too_long;
            wr_addr       = '0;
            wr_data.valid = 1'b1;
            wr_data.count = '0;
        end
    end

    msc_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram_ab (
        .i_clk      (i_clk),
        .i_we       (we),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr_a(rd_addr[0]),
        .i_rd_addr_b(rd_addr[1]),
        .o_rd_data_a(rd_data[0]),
        .o_rd_data_b(rd_data[1])
    );

    msc_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram_c (
        .i_clk      (i_clk),
        .i_we       (we),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr_a(rd_addr[2]),
        .i_rd_addr_b(rd_addr[2]),
        .o_rd_data_a(rd_data[2]),
        .o_rd_data_b()
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issuing <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= issue;
            if (in_xfer) begin
                r_issuing <= !too_long && !len_zero;
            end else if (issue && (r_iss == r_n)) begin
                r_issuing <= 1'b0;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_n            <= AW'(i_rod_length);
            r_iss          <= AW'(1);
            r_res_possible <= !too_long;
            r_res_count    <= '0;
        end else if (issue) begin
            r_iss <= r_iss + AW'(1);
        end
        if (done) begin
            r_res_possible <= calc_entry.valid;
            if (!calc_entry.valid) begin
                r_res_count <= '0;
            end else if (DW'(calc_entry.count) > COUNT_MAX_EXT) begin
                r_res_count <= COUNT_MAX;
            end else begin
                r_res_count <= COUNT_W'(calc_entry.count);
            end
        end
        r_cmp_idx  <= r_iss;
        r_use      <= use_k;
        r_fwd      <= fwd_k;
        r_fwd_data <= calc_entry;
        if (load_out) begin
            o_piece_count <= r_res_count;
            o_possible    <= r_res_possible;
        end
    end

    assign o_valid = r_out_vld;

endmodule

`default_nettype wire
